### rtl/pru_pkg.sv
// Shared types, constants and helper functions of the PNG row unfilter.
package pru_pkg;

   // default sizes of the row store and of the left-neighbor history
   localparam int MAX_ROW_BYTES_DEF   = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 8;

   // field widths of the configuration registers
   localparam int COLORS_W  = 3;
   localparam int BPC_W     = 5;
   localparam int COLUMNS_W = 14;

   // register reset values
   localparam logic [COLORS_W-1:0]  COLORS_RST  = COLORS_W'(1);
   localparam logic [BPC_W-1:0]     BPC_RST     = BPC_W'(8);
   localparam logic [COLUMNS_W-1:0] COLUMNS_RST = COLUMNS_W'(1);

   // CSR bus geometry: three 32-bit registers at byte addresses 0, 4, 8
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_COLORS  = 2'd0,
      CSR_BPC     = 2'd1,
      CSR_COLUMNS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FLT_NONE  = 3'd0,
      FLT_SUB   = 3'd1,
      FLT_UP    = 3'd2,
      FLT_AVG   = 3'd3,
      FLT_PAETH = 3'd4
   } filter_type;

   // Paeth predictor without forming p: |p-a|=|b-c|, |p-b|=|a-c|, |p-c|=|a+b-2c|
   function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic [9:0] pa;
      logic [9:0] pb;
      logic [9:0] pc;
      logic [9:0] sum_ab;
      logic [9:0] two_c;
      pa = (b > c) ? ({2'b00, b} - {2'b00, c}) : ({2'b00, c} - {2'b00, b});
      pb = (a > c) ? ({2'b00, a} - {2'b00, c}) : ({2'b00, c} - {2'b00, a});
      sum_ab = {2'b00, a} + {2'b00, b};
      two_c  = {1'b0, c, 1'b0};
      pc = (sum_ab > two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end else begin
         return c;
      end
   endfunction

endpackage

### rtl/png_row_unfilter_top.sv
// PNG row unfilter: reverses the None/Sub/Up/Average/Paeth row filters of a
// predictor stream, one byte per word. The block sustains one input word per
// clock cycle while rsp_stall is low; a reconstructed byte passes the input
// word register and then the result register, and tag words give no result.
// The left-neighbor history register feeds each result back as the left
// neighbor of a later byte, and the row store's single read port is addressed
// ahead at the next column. The row store holds MAX_ROW_BYTES bytes and has
// no clearing pass: the first row reads its upper neighbors as zero, so the
// store needs no initialization. Geometry is written through the CSR port at
// 0x0 (colors), 0x4 (bits per component) and 0x8 (columns); the derived row
// and pixel byte counts settle in the cycle after a write.
module png_row_unfilter_top #(
   parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pru_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pru_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pru_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_in_value,
   input  logic                            req_in_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_value,
   output logic                            rsp_out_last
);

   import pru_pkg::*;

   localparam int RW = $clog2(MAX_ROW_BYTES + 1);
   localparam int PW = $clog2(MAX_PIXEL_BYTES + 1);

   logic [RW-1:0] row_bytes;
   logic [PW-1:0] pixel_bytes;

   pru_cfg #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .row_bytes   (row_bytes),
      .pixel_bytes (pixel_bytes)
   );

   pru_core #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .row_bytes     (row_bytes),
      .pixel_bytes   (pixel_bytes),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_value  (req_in_value),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

### rtl/pru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pru_cfg.sv
// CSR block: image geometry registers and the derived row and pixel byte counts.
module pru_cfg #(
   parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF,
   localparam int RW = $clog2(MAX_ROW_BYTES + 1),
   localparam int PW = $clog2(MAX_PIXEL_BYTES + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pru_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pru_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pru_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [RW-1:0]                   row_bytes,
   output logic [PW-1:0]                   pixel_bytes
);

   import pru_pkg::*;

   logic [COLORS_W-1:0]  colors_ff;
   logic [BPC_W-1:0]     bpc_ff;
   logic [COLUMNS_W-1:0] columns_ff;
   logic [RW-1:0]        row_bytes_ff;
   logic [RW-1:0]        row_bytes_in;
   logic [PW-1:0]        pixel_bytes_ff;
   logic [PW-1:0]        pixel_bytes_in;

   csr_index_type        wr_index;
   logic                 wr_fire;
   logic [7:0]           comp_bits;
   logic [21:0]          row_bits;
   logic [19:0]          row_len;
   logic [4:0]           pix_len;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_index   = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         colors_ff  <= COLORS_RST;
         bpc_ff     <= BPC_RST;
         columns_ff <= COLUMNS_RST;
      end else if (wr_fire) begin
         case (wr_index)
            CSR_COLORS:  colors_ff  <= csr_pwdata[COLORS_W-1:0];
            CSR_BPC:     bpc_ff     <= csr_pwdata[BPC_W-1:0];
            CSR_COLUMNS: columns_ff <= csr_pwdata[COLUMNS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wr_index)
         CSR_COLORS:  csr_prdata = CSR_DATA_W'(colors_ff);
         CSR_BPC:     csr_prdata = CSR_DATA_W'(bpc_ff);
         CSR_COLUMNS: csr_prdata = CSR_DATA_W'(columns_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // byte counts, rounded up and clipped to the store sizes
   always_comb begin
      comp_bits = 8'(colors_ff) * 8'(bpc_ff);
      row_bits  = 22'(comp_bits) * 22'(columns_ff);
      row_len   = 20'((23'(row_bits) + 23'd7) >> 3);
      pix_len   = 5'((9'(comp_bits) + 9'd7) >> 3);
      if (32'(row_len) > 32'(MAX_ROW_BYTES)) begin
         row_bytes_in = RW'(MAX_ROW_BYTES);
      end else begin
         row_bytes_in = RW'(row_len);
      end
      if (32'(pix_len) > 32'(MAX_PIXEL_BYTES)) begin
         pixel_bytes_in = PW'(MAX_PIXEL_BYTES);
      end else begin
         pixel_bytes_in = PW'(pix_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= RW'(1);
         pixel_bytes_ff <= PW'(1);
      end else begin
         row_bytes_ff   <= row_bytes_in;
         pixel_bytes_ff <= pixel_bytes_in;
      end
   end

   assign row_bytes   = row_bytes_ff;
   assign pixel_bytes = pixel_bytes_ff;

endmodule

### rtl/pru_core.sv
// Filter reconstruction datapath: input word register, row state, row store and result register.
module pru_core #(
   parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF,
   localparam int RW = $clog2(MAX_ROW_BYTES + 1),
   localparam int PW = $clog2(MAX_PIXEL_BYTES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [RW-1:0] row_bytes,
   input  logic [PW-1:0] pixel_bytes,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_in_value,
   input  logic          req_in_last,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_value,
   output logic          rsp_out_last
);

   import pru_pkg::*;

   localparam int IW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int CW = IW + PW;
   localparam int XW = IW + RW + 1;

   // input word register
   logic          in_vld_ff, in_vld_in;
   logic [7:0]    in_value_ff;
   logic          in_last_ff;

   // row state
   logic [IW-1:0] idx_ff, idx_in;
   filter_type    kind_ff, kind_in;
   logic          await_tag_ff, await_tag_in;
   logic          first_row_ff, first_row_in;
   logic [7:0]    recent_out_ff [MAX_PIXEL_BYTES];
   logic [7:0]    recent_out_in [MAX_PIXEL_BYTES];
   logic [7:0]    recent_up_ff  [MAX_PIXEL_BYTES];
   logic [7:0]    recent_up_in  [MAX_PIXEL_BYTES];

   // result register
   logic          out_vld_ff, out_vld_in;
   logic [7:0]    out_value_ff;
   logic          out_last_ff;

   // row store read bypass
   logic          byp_ff, byp_in;
   logic [7:0]    byp_data_ff;

   logic          accept, advance, emit;
   logic [7:0]    mem_rd_data;
   logic [7:0]    up_byte;
   logic [7:0]    a_byte, b_byte, c_byte, r_byte;
   logic [8:0]    avg_sum;
   logic          has_left;
   logic [SW-1:0] left_sel;
   logic [IW:0]   idx_inc;
   filter_type    tag_kind;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign emit      = advance && !await_tag_ff;

   always_comb begin
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      if (emit) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // neighbors of the current byte
   always_comb begin
      has_left = (pixel_bytes != '0) && (CW'(idx_ff) >= CW'(pixel_bytes));
      left_sel = SW'(pixel_bytes - PW'(1));
      up_byte  = byp_ff ? byp_data_ff : mem_rd_data;
      a_byte   = has_left ? recent_out_ff[left_sel] : 8'd0;
      b_byte   = first_row_ff ? 8'd0 : up_byte;
      c_byte   = (has_left && !first_row_ff) ? recent_up_ff[left_sel] : 8'd0;
      avg_sum  = {1'b0, a_byte} + {1'b0, b_byte};
      case (kind_ff)
         FLT_SUB:   r_byte = in_value_ff + a_byte;
         FLT_UP:    r_byte = in_value_ff + b_byte;
         FLT_AVG:   r_byte = in_value_ff + avg_sum[8:1];
         FLT_PAETH: r_byte = in_value_ff + paeth_pred(a_byte, b_byte, c_byte);
         default:   r_byte = in_value_ff;
      endcase
      tag_kind = (in_value_ff > 8'd4) ? FLT_NONE : filter_type'(in_value_ff[2:0]);
      idx_inc  = {1'b0, idx_ff} + (IW + 1)'(1);
   end

   always_comb begin
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      await_tag_in = await_tag_ff;
      first_row_in = first_row_ff;
      recent_out_in = recent_out_ff;
      recent_up_in  = recent_up_ff;
      if (advance) begin
         if (await_tag_ff) begin
            // an empty row keeps every byte a tag
            if (row_bytes != '0) begin
               kind_in      = tag_kind;
               idx_in       = '0;
               await_tag_in = 1'b0;
            end
         end else begin
            recent_out_in[0] = r_byte;
            recent_up_in[0]  = b_byte;
            for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
               recent_out_in[k] = recent_out_ff[k-1];
               recent_up_in[k]  = recent_up_ff[k-1];
            end
            if (XW'(idx_inc) >= XW'(row_bytes)) begin
               idx_in       = '0;
               kind_in      = FLT_NONE;
               await_tag_in = 1'b1;
               first_row_in = 1'b0;
               for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                  recent_out_in[k] = 8'd0;
                  recent_up_in[k]  = 8'd0;
               end
            end else begin
               idx_in = idx_inc[IW-1:0];
            end
         end
         if (in_last_ff) begin
            idx_in       = '0;
            kind_in      = FLT_NONE;
            await_tag_in = 1'b1;
            first_row_in = 1'b1;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               recent_out_in[k] = 8'd0;
               recent_up_in[k]  = 8'd0;
            end
         end
      end
   end

   // store is read ahead at the next column; catch a write to that same entry
   assign byp_in = emit && (idx_ff == idx_in);

   pru_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (idx_ff),
      .wr_data (r_byte),
      .rd_addr (idx_in),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         idx_ff       <= '0;
         kind_ff      <= FLT_NONE;
         await_tag_ff <= 1'b1;
         first_row_ff <= 1'b1;
         byp_ff       <= 1'b0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            recent_out_ff[k] <= 8'd0;
            recent_up_ff[k]  <= 8'd0;
         end
      end else begin
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
         idx_ff        <= idx_in;
         kind_ff       <= kind_in;
         await_tag_ff  <= await_tag_in;
         first_row_ff  <= first_row_in;
         byp_ff        <= byp_in;
         recent_out_ff <= recent_out_in;
         recent_up_ff  <= recent_up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_value_ff <= req_in_value;
         in_last_ff  <= req_in_last;
      end
      if (emit) begin
         out_value_ff <= r_byte;
         out_last_ff  <= in_last_ff;
      end
      byp_data_ff <= r_byte;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_last  = out_last_ff;

`ifndef SYNTHESIS
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> await_tag_ff && first_row_ff)
      else $error("final word did not return to first-row tag state");

   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_vld_ff)
      else $error("reconstructed word not presented");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_tag_idx_zero: assert property (@(posedge clock) disable iff (reset)
      await_tag_ff |-> idx_ff == '0)
      else $error("column index not cleared while awaiting tag");

   a_bypass_after_write: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> $past(emit))
      else $error("row store bypass without a preceding write");
`endif

endmodule
